// ===== rtl/core/sbm_pkg.sv =====
// sbm_pkg: shared types, field widths and constants of the spectrum band meter
// no dependencies; every other file refers to it by scoped names
package sbm_pkg;

  localparam int NUM_BANDS_DEF = 32;
  localparam int FFT_SIZE_DEF  = 4096;

  localparam int BIN_W  = 11;
  localparam int CPX_W  = 24;
  localparam int BAND_W = 5;
  localparam int GAIN_W = 16;
  localparam int MAG_W  = 27;
  localparam int SUM_W  = 36;
  localparam int COEF_W = 16;

  // shared serial multiplier: a operand up to the band sum, b operand up to a component
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int ROOT_W = 24;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int DVD_W  = 40;

  localparam logic [COEF_W-1:0] RELEASE_RESET = 16'd1311;
  localparam logic [MAG_W-1:0]  MAG_MAX       = {MAG_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX       = {SUM_W{1'b1}};
  localparam logic [BIN_W-1:0]  BIN_MAX       = {BIN_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_BIN       = 2'd0,
    MODE_TABLE     = 2'd1,
    MODE_CLR_PEAK  = 2'd2,
    MODE_CLR_ALL   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [BIN_W-1:0]        bin_index;
    logic signed [CPX_W-1:0] re;
    logic signed [CPX_W-1:0] im;
    logic [BAND_W-1:0]       band_index;
    logic [BIN_W-1:0]        band_end_bin;
    logic [GAIN_W-1:0]       band_gain;
  } in_item_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [MAG_W-1:0]  magnitude;
    logic [MAG_W-1:0]  peak;
    logic              last_band;
  } out_item_t;

endpackage

// ===== rtl/core/sbm_mul.sv =====
// sbm_mul: shift-add multiplier, one multiplier bit per cycle
// depends on sbm_pkg for operand widths
module sbm_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sbm_pkg::MUL_A_W-1:0] a,
  input  logic [sbm_pkg::MUL_B_W-1:0] b,
  output logic                        done,
  output logic [sbm_pkg::MUL_P_W-1:0] p
);

  localparam int CNT_W = $clog2(sbm_pkg::MUL_B_W);

  logic [sbm_pkg::MUL_P_W-1:0] mcand;
  logic [sbm_pkg::MUL_B_W-1:0] mplier;
  logic [CNT_W-1:0]            cnt;
  logic                        running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == '0);
      if (start) begin
        running <= 1'b1;
      end else if (running && (cnt == '0)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p      <= '0;
      mcand  <= sbm_pkg::MUL_P_W'(a);
      mplier <= b;
      cnt    <= CNT_W'(sbm_pkg::MUL_B_W - 1);
    end else if (running) begin
      if (mplier[0]) begin
        p <= p + mcand;
      end
      mcand  <= {mcand[sbm_pkg::MUL_P_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[sbm_pkg::MUL_B_W-1:1]};
      cnt    <= cnt - 1'b1;
    end
  end

endmodule

// ===== rtl/core/sbm_isqrt.sv =====
// sbm_isqrt: digit-by-digit integer square root, one root bit per cycle
// depends on sbm_pkg for radicand and root widths
module sbm_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sbm_pkg::RAD_W-1:0]  n,
  output logic                       done,
  output logic [sbm_pkg::ROOT_W-1:0] root
);

  localparam int RW    = sbm_pkg::ROOT_W;
  localparam int CNT_W = $clog2(RW);

  logic [RW+1:0]              rem;
  logic [sbm_pkg::RAD_W-1:0]  nsh;
  logic [CNT_W-1:0]           cnt;
  logic                       running;
  logic [RW+3:0]              r4;
  logic [RW+3:0]              trial;

  assign r4    = {rem, nsh[sbm_pkg::RAD_W-1 -: 2]};
  assign trial = (RW+4)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == '0);
      if (start) begin
        running <= 1'b1;
      end else if (running && (cnt == '0)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      root <= '0;
      nsh  <= n;
      cnt  <= CNT_W'(RW - 1);
    end else if (running) begin
      nsh <= {nsh[sbm_pkg::RAD_W-3:0], 2'b00};
      cnt <= cnt - 1'b1;
      if (r4 >= trial) begin
        rem  <= (RW+2)'(r4 - trial);
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= r4[RW+1:0];
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/sbm_div.sv =====
// sbm_div: restoring divider, one quotient bit per cycle
// depends on sbm_pkg for dividend and bin widths
module sbm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sbm_pkg::DVD_W-1:0] dividend,
  input  logic [sbm_pkg::BIN_W-1:0] divisor,
  output logic                      done,
  output logic [sbm_pkg::DVD_W-1:0] quotient
);

  localparam int DW    = sbm_pkg::DVD_W;
  localparam int BW    = sbm_pkg::BIN_W;
  localparam int CNT_W = $clog2(DW);

  logic [BW-1:0]    rem;
  logic [BW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [BW:0]      t;

  // quotient register shifts the dividend out as quotient bits come in
  assign t = {rem, quotient[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == '0);
      if (start) begin
        running <= 1'b1;
      end else if (running && (cnt == '0)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
      cnt      <= CNT_W'(DW - 1);
    end else if (running) begin
      cnt <= cnt - 1'b1;
      if (t >= {1'b0, dsr}) begin
        rem      <= BW'(t - {1'b0, dsr});
        quotient <= {quotient[DW-2:0], 1'b1};
      end else begin
        rem      <= t[BW-1:0];
        quotient <= {quotient[DW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/spectrum_band_meter.sv =====
// spectrum_band_meter: FFT band meter with release smoothing and peak hold
// depends on sbm_pkg, sbm_mul, sbm_isqrt and sbm_div
//
// usage: items arrive on in_valid/in_ready as in_item_t. mode selects a spectrum
// bin, a band table write, clear peaks or clear all. bins come in ascending order,
// bin 1 starts a frame. a bin that reaches the current band's end bin closes the
// band and produces one out_item_t transaction on out_valid/out_ready.
// cfg_we/cfg_wdata write release_coef; the user writes it only while the block is
// idle, which the block itself does not enforce. throughput: one item at a time.
// table writes and clears leave the block idle. a bin that does not close a band
// runs two multiplies (re and im squared) and the square root; a closing bin adds
// a gain multiply, a divide and, on release, a further multiply, all on the
// bit-serial multiplier, root and divider units.
// reset: peaks and smoothed values read as zero, frame restarts, release_coef
// returns to 1311; band tables hold nothing until written.
// stall: a finished result waits in the output register; the next item is taken
// meanwhile and a later result waits until that register is free.
module spectrum_band_meter #(
  parameter int FFT_SIZE  = sbm_pkg::FFT_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sbm_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sbm_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [sbm_pkg::COEF_W-1:0] cfg_wdata
);

  localparam int NUM_BANDS = sbm_pkg::NUM_BANDS_DEF;
  localparam int IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CB_W  = $clog2(NUM_BANDS + 1);
  localparam int unsigned HALF_FFT = FFT_SIZE / 2;
  localparam int MW = sbm_pkg::MAG_W;
  localparam int BW = sbm_pkg::BIN_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQA  = 9'b000000010,
    S_SQB  = 9'b000000100,
    S_SQRT = 9'b000001000,
    S_GMUL = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_RMUL = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state;

  logic [sbm_pkg::COEF_W-1:0] release_coef;
  logic [CB_W-1:0]            cb;
  logic [BW-1:0]              first_bin;
  logic [sbm_pkg::SUM_W-1:0]  sum;
  logic [BW-1:0]              bin;
  logic [sbm_pkg::CPX_W-1:0]  b_abs;
  logic [sbm_pkg::RAD_W-1:0]  sq_a;
  logic [MW-1:0]              m_new;
  sbm_pkg::out_item_t         res;

  logic [BW-1:0]              end_mem  [NUM_BANDS];
  logic [sbm_pkg::GAIN_W-1:0] gain_mem [NUM_BANDS];
  logic [MW-1:0]              sm_mem   [NUM_BANDS];
  logic [MW-1:0]              pk_mem   [NUM_BANDS];
  logic [NUM_BANDS-1:0]       sm_vld;
  logic [NUM_BANDS-1:0]       pk_vld;
  logic [BW-1:0]              end_q;
  logic [sbm_pkg::GAIN_W-1:0] gain_q;
  logic [MW-1:0]              sm_q;
  logic [MW-1:0]              pk_q;

  logic                        mul_start;
  logic [sbm_pkg::MUL_A_W-1:0] mul_a;
  logic [sbm_pkg::MUL_B_W-1:0] mul_b;
  logic                        mul_done;
  logic [sbm_pkg::MUL_P_W-1:0] mul_p;
  logic                        sqrt_start;
  logic                        sqrt_done;
  logic [sbm_pkg::ROOT_W-1:0]  root;
  logic                        div_start;
  logic                        div_done;
  logic [sbm_pkg::DVD_W-1:0]   quot;

  logic [IDX_W-1:0]            cb_idx;
  logic                        accept;
  logic [sbm_pkg::CPX_W-1:0]   re_abs_in;
  logic [sbm_pkg::CPX_W-1:0]   im_abs_in;
  logic                        bin_ok;
  logic                        restart;
  logic                        proceed;
  logic [sbm_pkg::SUM_W:0]     sum_wide;
  logic [sbm_pkg::SUM_W-1:0]   sum_new;
  logic                        close;
  logic [BW-1:0]               count;
  logic [MW-1:0]               val_c;
  logic [MW-1:0]               sm_cur;
  logic [MW-1:0]               pk_cur;
  logic [MW-1:0]               diff;
  logic [MW-1:0]               pk_new;
  logic                        out_free;
  logic                        out_load;

  assign cb_idx    = cb[IDX_W-1:0];
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign re_abs_in = in_data.re[sbm_pkg::CPX_W-1] ? sbm_pkg::CPX_W'(-in_data.re) : in_data.re;
  assign im_abs_in = in_data.im[sbm_pkg::CPX_W-1] ? sbm_pkg::CPX_W'(-in_data.im) : in_data.im;
  assign bin_ok    = (in_data.bin_index != '0) && (32'(in_data.bin_index) < HALF_FFT);
  assign restart   = (in_data.bin_index == BW'(1));
  assign proceed   = bin_ok && (restart || (cb < CB_W'(NUM_BANDS)));

  assign sum_wide = {1'b0, sum} + (sbm_pkg::SUM_W + 1)'(root);
  assign sum_new  = sum_wide[sbm_pkg::SUM_W] ? sbm_pkg::SUM_MAX : sum_wide[sbm_pkg::SUM_W-1:0];
  assign close    = (bin >= end_q);
  // bin below the band start counts as one bin
  assign count    = (bin >= first_bin) ? BW'(bin - first_bin + BW'(1)) : BW'(1);
  assign val_c    = (quot > sbm_pkg::DVD_W'(sbm_pkg::MAG_MAX)) ? sbm_pkg::MAG_MAX : quot[MW-1:0];
  assign sm_cur   = sm_vld[cb_idx] ? sm_q : '0;
  assign pk_cur   = pk_vld[cb_idx] ? pk_q : '0;
  assign diff     = sm_cur - val_c;
  assign pk_new   = (m_new > pk_cur) ? m_new : pk_cur;
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == S_OUT) && out_free;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_IDLE: begin
        mul_start = accept && (in_data.mode == sbm_pkg::MODE_BIN) && proceed;
        mul_a     = sbm_pkg::MUL_A_W'(re_abs_in);
        mul_b     = sbm_pkg::MUL_B_W'(re_abs_in);
      end
      S_SQA: begin
        mul_start = mul_done;
        mul_a     = sbm_pkg::MUL_A_W'(b_abs);
        mul_b     = sbm_pkg::MUL_B_W'(b_abs);
      end
      S_SQRT: begin
        mul_start = sqrt_done && close;
        mul_a     = sum_new;
        mul_b     = sbm_pkg::MUL_B_W'(gain_q);
      end
      S_DIV: begin
        mul_start = div_done && !(val_c > sm_cur);
        mul_a     = sbm_pkg::MUL_A_W'(diff);
        mul_b     = sbm_pkg::MUL_B_W'(release_coef);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign sqrt_start = (state == S_SQB) && mul_done;
  assign div_start  = (state == S_GMUL) && mul_done;

  sbm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  sbm_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .n     (sq_a + mul_p[sbm_pkg::RAD_W-1:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  // gain is Q4.12: dropping 12 product bits before dividing by count is exact
  sbm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p[sbm_pkg::DVD_W+11:12]),
    .divisor  (count),
    .done     (div_done),
    .quotient (quot)
  );

  // band tables and per-band stores, registered reads at the current band
  always_ff @(posedge clk) begin
    if (accept && (in_data.mode == sbm_pkg::MODE_TABLE) &&
        (32'(in_data.band_index) < NUM_BANDS)) begin
      end_mem[IDX_W'(in_data.band_index)]  <= in_data.band_end_bin;
      gain_mem[IDX_W'(in_data.band_index)] <= in_data.band_gain;
    end
    if (state == S_UPD) begin
      sm_mem[cb_idx] <= m_new;
      pk_mem[cb_idx] <= pk_new;
    end
    end_q  <= end_mem[cb_idx];
    gain_q <= gain_mem[cb_idx];
    sm_q   <= sm_mem[cb_idx];
    pk_q   <= pk_mem[cb_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      release_coef <= sbm_pkg::RELEASE_RESET;
      cb           <= '0;
      first_bin    <= BW'(1);
      sum          <= '0;
      sm_vld       <= '0;
      pk_vld       <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        release_coef <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.mode)
              sbm_pkg::MODE_BIN: begin
                if (bin_ok && restart) begin
                  cb        <= '0;
                  first_bin <= BW'(1);
                  sum       <= '0;
                end
                if (proceed) begin
                  state <= S_SQA;
                end
              end
              sbm_pkg::MODE_CLR_PEAK: begin
                pk_vld <= '0;
              end
              sbm_pkg::MODE_CLR_ALL: begin
                pk_vld    <= '0;
                sm_vld    <= '0;
                cb        <= '0;
                first_bin <= BW'(1);
                sum       <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SQA: begin
          if (mul_done) begin
            state <= S_SQB;
          end
        end
        S_SQB: begin
          if (mul_done) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            sum   <= sum_new;
            state <= close ? S_GMUL : S_IDLE;
          end
        end
        S_GMUL: begin
          if (mul_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= (val_c > sm_cur) ? S_UPD : S_RMUL;
          end
        end
        S_RMUL: begin
          if (mul_done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          sm_vld[cb_idx] <= 1'b1;
          pk_vld[cb_idx] <= 1'b1;
          state          <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            cb        <= cb + 1'b1;
            first_bin <= (bin >= sbm_pkg::BIN_MAX) ? sbm_pkg::BIN_MAX : bin + BW'(1);
            sum       <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item and datapath holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      bin   <= in_data.bin_index;
      b_abs <= im_abs_in;
    end
    if ((state == S_SQA) && mul_done) begin
      sq_a <= mul_p[sbm_pkg::RAD_W-1:0];
    end
    if ((state == S_DIV) && div_done) begin
      m_new <= (val_c > sm_cur) ? val_c : sm_cur;
    end
    if ((state == S_RMUL) && mul_done) begin
      m_new <= m_new - mul_p[MW+15:16];
    end
    if (state == S_UPD) begin
      res.band      <= sbm_pkg::BAND_W'(cb);
      res.magnitude <= m_new;
      res.peak      <= pk_new;
      res.last_band <= (cb == CB_W'(NUM_BANDS - 1));
    end
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule

// ===== rtl/core/sbm_checker.sv =====
// sbm_checker: port-level assertions for the spectrum band meter, bound to the top
// depends on sbm_pkg and spectrum_band_meter
module sbm_checker #(
  parameter int NUM_BANDS = sbm_pkg::NUM_BANDS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input sbm_pkg::in_item_t          in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input sbm_pkg::out_item_t         out_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_peak_ge_mag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.peak >= out_data.magnitude)
    else $error("peak below smoothed magnitude");

  a_last_band: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_band |-> out_data.band == sbm_pkg::BAND_W'(NUM_BANDS - 1))
    else $error("last band flag on wrong band");

  // table writes and clears leave the input ready again in the following cycle
  a_ctrl_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.mode != sbm_pkg::MODE_BIN) |=> in_ready)
    else $error("control transaction left input blocked");

endmodule

bind spectrum_band_meter sbm_checker #(.NUM_BANDS(NUM_BANDS)) u_sbm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for spectrum_band_meter
// depends on sbm_pkg and the spectrum_band_meter rtl with its sbm_mul, sbm_isqrt and sbm_div units
`timescale 1ns / 1ps

module tb_top;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  sbm_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  sbm_pkg::out_item_t out_data;
  logic cfg_we;
  logic [sbm_pkg::COEF_W-1:0] cfg_wdata;

  spectrum_band_meter u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [sbm_pkg::BIN_W-1:0]  end_tbl[32];
  logic [sbm_pkg::GAIN_W-1:0] gain_tbl[32];
  logic [sbm_pkg::MAG_W-1:0]  smooth_mag[32];
  logic [sbm_pkg::MAG_W-1:0]  held_peak[32];
  int unsigned                cur_band;
  logic [sbm_pkg::BIN_W-1:0]  first_bin;
  logic [sbm_pkg::SUM_W-1:0]  band_sum;
  logic [sbm_pkg::COEF_W-1:0] rel_coef;

  sbm_pkg::out_item_t band_q[$];
  int errors;
  int bin_count;
  int send_idle_pct;
  int stall_pct;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint unsigned root24(longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 23; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic void restart_frame();
    cur_band = 0;
    first_bin = sbm_pkg::BIN_W'(1);
    band_sum = '0;
  endfunction

  // returns 1 when the item closes a band
  function automatic bit meter_band(input sbm_pkg::in_item_t it,
                                    output sbm_pkg::out_item_t o);
    longint a;
    longint b;
    longint unsigned s;
    longint unsigned cnt;
    longint unsigned val;
    longint unsigned dec;
    logic [sbm_pkg::MAG_W-1:0] m;
    int unsigned k;
    o = '0;
    case (sbm_pkg::mode_t'(it.mode))
      sbm_pkg::MODE_TABLE: begin
        end_tbl[it.band_index] = it.band_end_bin;
        gain_tbl[it.band_index] = it.band_gain;
        return 0;
      end
      sbm_pkg::MODE_CLR_PEAK: begin
        foreach (held_peak[i]) held_peak[i] = '0;
        return 0;
      end
      sbm_pkg::MODE_CLR_ALL: begin
        foreach (held_peak[i]) begin
          held_peak[i] = '0;
          smooth_mag[i] = '0;
        end
        restart_frame();
        return 0;
      end
      default: ;
    endcase
    if (it.bin_index == 0 || it.bin_index >= sbm_pkg::FFT_SIZE_DEF / 2) return 0;
    if (it.bin_index == 1) restart_frame();
    if (cur_band >= sbm_pkg::NUM_BANDS_DEF) return 0;
    a = it.re;
    b = it.im;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    s = longint'(band_sum) + root24(a * a + b * b);
    band_sum = (s > longint'(sbm_pkg::SUM_MAX)) ? sbm_pkg::SUM_MAX : s[sbm_pkg::SUM_W-1:0];
    k = cur_band;
    if (it.bin_index < end_tbl[k]) return 0;
    cnt = (it.bin_index >= first_bin) ? it.bin_index + 1 - first_bin : 1;
    val = (longint'(gain_tbl[k]) * band_sum) / (cnt * 4096);
    if (val > sbm_pkg::MAG_MAX) val = sbm_pkg::MAG_MAX;
    m = smooth_mag[k];
    if (val > m) begin
      m = val[sbm_pkg::MAG_W-1:0];
    end else begin
      dec = ((longint'(m) - val) * rel_coef) >> 16;
      m = m - dec[sbm_pkg::MAG_W-1:0];
    end
    smooth_mag[k] = m;
    if (m > held_peak[k]) held_peak[k] = m;
    o.band = k[sbm_pkg::BAND_W-1:0];
    o.magnitude = m;
    o.peak = held_peak[k];
    o.last_band = (k == sbm_pkg::NUM_BANDS_DEF - 1);
    cur_band = k + 1;
    first_bin = (it.bin_index >= sbm_pkg::BIN_MAX) ? sbm_pkg::BIN_MAX :
                sbm_pkg::BIN_W'(it.bin_index + 1);
    band_sum = '0;
    return 1;
  endfunction

  // one transaction on the input channel; typed results replace the predicted one
  task automatic send_item(input sbm_pkg::in_item_t it, input bit typed = 0,
                           input sbm_pkg::out_item_t typed_exp = '0);
    sbm_pkg::out_item_t o;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (meter_band(it, o)) band_q.push_back(typed ? typed_exp : o);
    if (it.mode == sbm_pkg::MODE_BIN) bin_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (band_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_coef(input logic [sbm_pkg::COEF_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rel_coef = v;
  endtask

  function automatic sbm_pkg::in_item_t rand_item();
    sbm_pkg::in_item_t it;
    it.mode = 2'($urandom_range(3));
    it.bin_index = sbm_pkg::BIN_W'($urandom_range(2047));
    it.re = sbm_pkg::CPX_W'($urandom);
    it.im = sbm_pkg::CPX_W'($urandom);
    it.band_index = sbm_pkg::BAND_W'($urandom_range(31));
    it.band_end_bin = sbm_pkg::BIN_W'($urandom_range(1, 2047));
    it.band_gain = sbm_pkg::GAIN_W'($urandom_range(65535));
    return it;
  endfunction

  function automatic sbm_pkg::in_item_t bin_item(int bin, int re, int im);
    sbm_pkg::in_item_t it;
    it = rand_item();
    it.mode = sbm_pkg::MODE_BIN;
    it.bin_index = sbm_pkg::BIN_W'(bin);
    it.re = sbm_pkg::CPX_W'(re);
    it.im = sbm_pkg::CPX_W'(im);
    return it;
  endfunction

  // non-decreasing end bins, random gains
  task automatic load_tables(input int max_inc);
    sbm_pkg::in_item_t it;
    int e;
    e = $urandom_range(1, max_inc + 1);
    for (int k = 0; k < 32; k++) begin
      it = rand_item();
      it.mode = sbm_pkg::MODE_TABLE;
      it.band_index = sbm_pkg::BAND_W'(k);
      it.band_end_bin = sbm_pkg::BIN_W'((e > 2047) ? 2047 : e);
      it.band_gain = sbm_pkg::GAIN_W'($urandom_range(65535));
      send_item(it);
      e += $urandom_range(0, max_inc);
    end
  endtask

  // one frame of ascending bins starting at bin 1, with some noise mixed in
  task automatic run_frame(input int step_max);
    sbm_pkg::in_item_t it;
    int bin;
    int lim;
    bin = 1;
    lim = end_tbl[31] + 3;
    while (bin <= 2047 && bin <= lim) begin
      if ($urandom_range(99) < 8) begin
        it = rand_item();
        if (it.mode == sbm_pkg::MODE_TABLE) it.mode = sbm_pkg::MODE_BIN;
        send_item(it);
      end else begin
        if ($urandom_range(9) < 7) it = bin_item(bin, $urandom, $urandom);
        else it = bin_item(bin, $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20);
        send_item(it);
        bin += $urandom_range(1, step_max);
      end
    end
  endtask

  always @(posedge clk) begin
    sbm_pkg::out_item_t e;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (band_q.size() == 0) begin
        $display("%0t: unexpected band result %p", $realtime, out_data);
        errors++;
      end else begin
        e = band_q.pop_front();
        if (out_data.band !== e.band || out_data.magnitude !== e.magnitude ||
            out_data.peak !== e.peak || out_data.last_band !== e.last_band) begin
          $display("%0t: band result mismatch expected %p actual %p",
                   $realtime, e, out_data);
          errors++;
        end
      end
    end
  end

  typedef struct {
    sbm_pkg::in_item_t  it;
    bit                 typed;
    sbm_pkg::out_item_t exp;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    sbm_pkg::in_item_t it;
    logic [sbm_pkg::COEF_W-1:0] coefs[6];

    errors = 0;
    bin_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    foreach (end_tbl[i]) begin
      end_tbl[i] = '0;
      gain_tbl[i] = '0;
      smooth_mag[i] = '0;
      held_peak[i] = '0;
    end
    restart_frame();
    rel_coef = sbm_pkg::RELEASE_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // band layout for the directed part: equal end bins on bands 3 and 4
    for (int k = 0; k < 32; k++) begin
      it = rand_item();
      it.mode = sbm_pkg::MODE_TABLE;
      it.band_index = sbm_pkg::BAND_W'(k);
      it.band_end_bin = sbm_pkg::BIN_W'((k < 3) ? k + 1 : (k < 5) ? 5 : 5 + k);
      it.band_gain = (k == 1) ? 16'd0 : (k == 2) ? 16'hFFFF : 16'd4096;
      send_item(it);
    end

    r.typed = 1;
    r.it = bin_item(1, -8388608, -8388608);
    r.exp = '{band: 0, magnitude: 11863283, peak: 11863283, last_band: 0};
    rows.push_back(r);
    r.it = bin_item(2, 0, 0);
    r.exp = '{band: 1, magnitude: 0, peak: 0, last_band: 0};
    rows.push_back(r);
    // gain at full scale saturates the band value
    r.it = bin_item(3, -8388608, -8388608);
    r.exp = '{band: 2, magnitude: sbm_pkg::MAG_MAX, peak: sbm_pkg::MAG_MAX, last_band: 0};
    rows.push_back(r);
    r.typed = 0;
    r.exp = '0;
    r.it = bin_item(4, 8388607, 8388607); rows.push_back(r);
    r.it = bin_item(0, 8388607, -5);      rows.push_back(r);
    r.it = bin_item(5, -1, 1);            rows.push_back(r);
    // band 4 starts past bin 5, so this one closes with a count of one
    r.it = bin_item(5, 1000, -2000);      rows.push_back(r);
    r.it = rand_item(); r.it.mode = sbm_pkg::MODE_CLR_PEAK; rows.push_back(r);
    r.it = bin_item(1, 3, 4);             rows.push_back(r);
    r.it = bin_item(2, 3, 4);             rows.push_back(r);
    r.it = rand_item(); r.it.mode = sbm_pkg::MODE_CLR_ALL; rows.push_back(r);
    r.it = bin_item(1, 3, 4);             rows.push_back(r);
    r.it = bin_item(2047, 7, 7);          rows.push_back(r);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].exp);

    coefs = '{16'hFFFF, 16'd0, 16'd1, 16'($urandom), 16'($urandom), 16'hFFFF};
    for (int p = 0; p < 6; p++) begin
      int start;
      drain();
      write_coef(coefs[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      load_tables(p == 4 ? 120 : 2);
      start = bin_count;
      while (bin_count - start < 90) run_frame(p == 4 ? 60 : 2);
    end
    drain();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sbm_pkg.sv
rtl/core/sbm_mul.sv
rtl/core/sbm_isqrt.sv
rtl/core/sbm_div.sv
rtl/core/spectrum_band_meter.sv
rtl/core/sbm_checker.sv
tb/sv/tb_top.sv
